// ===== src/tmon_pkg.sv =====
// Shared constants and types for the temperature/battery hysteresis monitor.
package tmon_pkg;

    localparam int unsigned SampleWidth = 10;
    localparam int unsigned MarginWidth = 6;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_TEMP_WARN     = 3'd0;
    localparam logic [2:0] REG_TEMP_ERROR    = 3'd1;
    localparam logic [2:0] REG_BATTERY_WARN  = 3'd2;
    localparam logic [2:0] REG_BATTERY_ERROR = 3'd3;
    localparam logic [2:0] REG_HYSTERESIS    = 3'd4;

    // Register reset values
    localparam logic [SampleWidth-1:0] TEMP_WARN_RESET     = 10'd780;
    localparam logic [SampleWidth-1:0] TEMP_ERROR_RESET    = 10'd820;
    localparam logic [SampleWidth-1:0] BATTERY_WARN_RESET  = 10'd580;
    localparam logic [SampleWidth-1:0] BATTERY_ERROR_RESET = 10'd400;
    localparam logic [MarginWidth-1:0] HYSTERESIS_RESET    = 6'd5;

    // Sticky health flags
    typedef struct packed {
        logic battery_critical;
        logic battery_low;
        logic temp_critical;
        logic temp_high;
    } health_flags_t;

    // One result word, packed as on m_axis_tdata (lowest bit last in the list)
    typedef struct packed {
        logic          pad;
        health_flags_t flags;
        logic          outputs_enabled;
        logic          battery_alarm;
        logic          temp_alarm;
    } result_t;

endpackage

// ===== src/temp_battery_hysteresis_monitor.sv =====
// Top level: dual-threshold hysteresis monitor for temperature and battery samples.
// Path: a word taken on s_axis waits in the input register, moves into the result
//   register once that is empty or draining, and is offered on m_axis from there.
// Throughput: one word per cycle, sustained, with m_axis_tready held high.
// Reset: aresetn is synchronous, active low; it empties both registers, clears the
//   four health flags, holds outputs off and loads the default thresholds.
module temp_battery_hysteresis_monitor (
    input  logic        aclk,
    input  logic        aresetn,

    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [9:0] temp_sample, [19:10] battery_sample, [23:20] zero
    input  logic [23:0] s_axis_tdata,
    // [0] temp_valid, [1] battery_valid
    input  logic [1:0]  s_axis_tuser,

    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] temp_alarm, [1] battery_alarm, [2] outputs_enabled, [3] temp_high_flag,
    // [4] temp_critical_flag, [5] battery_low_flag, [6] battery_critical_flag, [7] zero
    output logic [7:0]  m_axis_tdata,

    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned SW = tmon_pkg::SampleWidth;
    localparam int unsigned MW = tmon_pkg::MarginWidth;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SW-1:0] temp_warn_reg;
    logic [SW-1:0] temp_error_reg;
    logic [SW-1:0] battery_warn_reg;
    logic [SW-1:0] battery_error_reg;
    logic [MW-1:0] hysteresis_reg;

    logic          cfg_write;
    logic [2:0]    cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_warn_reg     <= tmon_pkg::TEMP_WARN_RESET;
            temp_error_reg    <= tmon_pkg::TEMP_ERROR_RESET;
            battery_warn_reg  <= tmon_pkg::BATTERY_WARN_RESET;
            battery_error_reg <= tmon_pkg::BATTERY_ERROR_RESET;
            hysteresis_reg    <= tmon_pkg::HYSTERESIS_RESET;
        end else if (cfg_write) begin
            // Addresses past the last register are dropped
            unique case (cfg_index)
                tmon_pkg::REG_TEMP_WARN:     temp_warn_reg     <= pwdata[SW-1:0];
                tmon_pkg::REG_TEMP_ERROR:    temp_error_reg    <= pwdata[SW-1:0];
                tmon_pkg::REG_BATTERY_WARN:  battery_warn_reg  <= pwdata[SW-1:0];
                tmon_pkg::REG_BATTERY_ERROR: battery_error_reg <= pwdata[SW-1:0];
                tmon_pkg::REG_HYSTERESIS:    hysteresis_reg    <= pwdata[MW-1:0];
                default: ;
            endcase
        end
    end

    // Read back: zero-extend each register to the bus width
    always_comb begin
        unique case (cfg_index)
            tmon_pkg::REG_TEMP_WARN:     prdata = {22'd0, temp_warn_reg};
            tmon_pkg::REG_TEMP_ERROR:    prdata = {22'd0, temp_error_reg};
            tmon_pkg::REG_BATTERY_WARN:  prdata = {22'd0, battery_warn_reg};
            tmon_pkg::REG_BATTERY_ERROR: prdata = {22'd0, battery_error_reg};
            tmon_pkg::REG_HYSTERESIS:    prdata = {26'd0, hysteresis_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic          in_valid_reg;
    logic          temp_ok_reg;
    logic [SW-1:0] temp_sample_reg;
    logic          battery_ok_reg;
    logic [SW-1:0] battery_sample_reg;

    logic          out_valid_reg;
    logic          advance;

    // Move the held word into the result register whenever that register is
    // empty or being drained this cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            temp_ok_reg        <= s_axis_tuser[0];
            temp_sample_reg    <= s_axis_tdata[SW-1:0];
            battery_ok_reg     <= s_axis_tuser[1];
            battery_sample_reg <= s_axis_tdata[2*SW-1:SW];
        end
    end

    // ------------------------------------------------------------------
    // Flag update
    // ------------------------------------------------------------------
    tmon_pkg::health_flags_t flags_reg;
    tmon_pkg::health_flags_t flags_next;
    logic                    enable_reg;
    logic                    enable_next;
    logic                    temp_alarm;
    logic                    battery_alarm;

    logic [SW:0]   temp_low_sum;    // sample + margin, one bit of headroom
    logic [SW:0]   battery_clear;   // warn + margin, one bit of headroom

    assign temp_low_sum  = {1'b0, temp_sample_reg} + {{(SW-MW+1){1'b0}}, hysteresis_reg};
    assign battery_clear = {1'b0, battery_warn_reg} + {{(SW-MW+1){1'b0}}, hysteresis_reg};

    always_comb begin
        flags_next    = flags_reg;
        enable_next   = enable_reg;
        temp_alarm    = 1'b0;
        battery_alarm = 1'b0;

        // Temperature: error over warn over clear, in that order
        if (temp_ok_reg) begin
            priority if (temp_sample_reg > temp_error_reg) begin
                temp_alarm              = !flags_reg.temp_critical;
                flags_next.temp_critical = 1'b1;
                enable_next             = 1'b0;
            end else if (temp_sample_reg > temp_warn_reg) begin
                temp_alarm           = !flags_reg.temp_high;
                flags_next.temp_high = 1'b1;
            end else if (temp_low_sum < {1'b0, temp_warn_reg}) begin
                flags_next.temp_high     = 1'b0;
                flags_next.temp_critical = 1'b0;
                enable_next              = 1'b1;
            end else begin
                // inside the hysteresis band: hold
            end
        end

        // Battery: same scheme mirrored; leaves the output enable alone
        if (battery_ok_reg) begin
            priority if (battery_sample_reg < battery_error_reg) begin
                battery_alarm               = !flags_reg.battery_critical;
                flags_next.battery_critical = 1'b1;
            end else if (battery_sample_reg < battery_warn_reg) begin
                battery_alarm          = !flags_reg.battery_low;
                flags_next.battery_low = 1'b1;
            end else if ({1'b0, battery_sample_reg} > battery_clear) begin
                flags_next.battery_low      = 1'b0;
                flags_next.battery_critical = 1'b0;
            end else begin
                // inside the hysteresis band: hold
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg  <= '0;
            enable_reg <= 1'b0;
        end else if (advance) begin
            flags_reg  <= flags_next;
            enable_reg <= enable_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    tmon_pkg::result_t result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg.pad             <= 1'b0;
            result_reg.flags           <= flags_next;
            result_reg.outputs_enabled <= enable_next;
            result_reg.battery_alarm   <= battery_alarm;
            result_reg.temp_alarm      <= temp_alarm;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = result_reg;

endmodule

// ===== src/tmon_checker.sv =====
// Port-level checker for the hysteresis monitor, bound to the top level.
module tmon_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    // A stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // Reset empties the result register
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A temperature alarm comes with a temperature flag set
    a_temp_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[3] || m_axis_tdata[4])
        else $error("temperature alarm without flag");

    // A battery alarm comes with a battery flag set
    a_batt_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[5] || m_axis_tdata[6])
        else $error("battery alarm without flag");

    // Critical temperature always holds the outputs off
    a_crit_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[4] |-> !m_axis_tdata[2])
        else $error("outputs enabled with critical temperature");

endmodule

bind temp_battery_hysteresis_monitor tmon_checker u_tmon_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/temp_battery_hysteresis_monitor_test.sv =====
// Self-checking stream testbench for the temperature/battery hysteresis monitor.
module temp_battery_hysteresis_monitor_test;

    localparam int unsigned SampleWidth = tmon_pkg::SampleWidth;
    localparam int unsigned MarginWidth = tmon_pkg::MarginWidth;
    localparam int          SampleMax   = (1 << SampleWidth) - 1;
    localparam int          SettleWait  = 4;     // two-stage pipe plus slack
    localparam int unsigned QuietLimit  = 2000;  // cycles without any handshake
    localparam logic [2:0]  REG_SPARE   = 3'd7;  // decodes to no register

    typedef struct {
        logic                   temp_valid;
        logic [SampleWidth-1:0] temp_sample;
        logic                   battery_valid;
        logic [SampleWidth-1:0] battery_sample;
    } sample_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [9:0] temp_sample, [19:10] battery_sample, [23:20] zero
    logic [23:0] s_axis_tdata = '0;
    // [0] temp_valid, [1] battery_valid
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [0] temp_alarm, [1] battery_alarm, [2] outputs_enabled, [3] temp_high_flag,
    // [4] temp_critical_flag, [5] battery_low_flag, [6] battery_critical_flag, [7] zero
    logic [7:0]  m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    temp_battery_hysteresis_monitor i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Local copy of the thresholds and the monitor state, advanced per accepted word.
    logic [SampleWidth-1:0]  lvl_temp_warn  = tmon_pkg::TEMP_WARN_RESET;
    logic [SampleWidth-1:0]  lvl_temp_error = tmon_pkg::TEMP_ERROR_RESET;
    logic [SampleWidth-1:0]  lvl_batt_warn  = tmon_pkg::BATTERY_WARN_RESET;
    logic [SampleWidth-1:0]  lvl_batt_error = tmon_pkg::BATTERY_ERROR_RESET;
    logic [MarginWidth-1:0]  hyst_margin    = tmon_pkg::HYSTERESIS_RESET;
    tmon_pkg::health_flags_t health         = '0;
    logic                    outputs_on     = 1'b0;

    sample_t           sample_queue[$];      // words waiting to be driven
    tmon_pkg::result_t expected_results[$];  // predicted result words, oldest first
    int                mismatch_count = 0;
    bit                idling_on = 1'b1;
    int                src_gap = 0;
    int                sink_gap = 0;
    logic              word_in_taken = 1'b0;
    int unsigned       quiet_cycles = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Apply one sample word to the health state and return the result word it yields.
    function automatic tmon_pkg::result_t predict_health(input sample_t s);
        tmon_pkg::result_t r;
        r = '0;
        if (s.temp_valid) begin
            if (s.temp_sample > lvl_temp_error) begin
                r.temp_alarm = !health.temp_critical;
                health.temp_critical = 1'b1;
                outputs_on = 1'b0;
            end else if (s.temp_sample > lvl_temp_warn) begin
                r.temp_alarm = !health.temp_high;
                health.temp_high = 1'b1;
            end else if (11'(s.temp_sample) + 11'(hyst_margin) < 11'(lvl_temp_warn)) begin
                // clear bound is compared without wrap below zero
                health.temp_high = 1'b0;
                health.temp_critical = 1'b0;
                outputs_on = 1'b1;
            end
        end
        if (s.battery_valid) begin
            if (s.battery_sample < lvl_batt_error) begin
                r.battery_alarm = !health.battery_critical;
                health.battery_critical = 1'b1;
            end else if (s.battery_sample < lvl_batt_warn) begin
                r.battery_alarm = !health.battery_low;
                health.battery_low = 1'b1;
            end else if (11'(s.battery_sample) > 11'(lvl_batt_warn) + 11'(hyst_margin)) begin
                // full-width sum: a clear bound past the top is never reached
                health.battery_low = 1'b0;
                health.battery_critical = 1'b0;
            end
        end
        r.flags = health;
        r.outputs_enabled = outputs_on;
        return r;
    endfunction

    // Pick a level, mostly close to one of three thresholds, sometimes anywhere or at the rails.
    function automatic logic [SampleWidth-1:0] pick_level(input int near_a, input int near_b,
                                                          input int near_c);
        int v;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = SampleMax;
            2, 3: v = $urandom_range(0, SampleMax);
            4, 5: v = near_a + int'($urandom_range(0, 6)) - 3;
            6, 7: v = near_b + int'($urandom_range(0, 6)) - 3;
            default: v = near_c + int'($urandom_range(0, 6)) - 3;
        endcase
        if (v < 0) v = 0;
        if (v > SampleMax) v = SampleMax;
        return v[SampleWidth-1:0];
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        s.temp_valid = ($urandom_range(0, 3) != 0);
        s.temp_sample = pick_level(int'(lvl_temp_warn), int'(lvl_temp_error),
                                   int'(lvl_temp_warn) - int'(hyst_margin));
        s.battery_valid = ($urandom_range(0, 3) != 0);
        s.battery_sample = pick_level(int'(lvl_batt_warn), int'(lvl_batt_error),
                                      int'(lvl_batt_warn) + int'(hyst_margin));
        return s;
    endfunction

    task automatic queue_sample(input logic tv, input int t, input logic bv, input int b);
        sample_t s;
        s.temp_valid = tv;
        s.temp_sample = t[SampleWidth-1:0];
        s.battery_valid = bv;
        s.battery_sample = b[SampleWidth-1:0];
        sample_queue.push_back(s);
    endtask

    // Hold until every queued word went in and every result came back, then let the pipe empty.
    task automatic settle();
        do @(posedge aclk);
        while (sample_queue.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (SettleWait) @(posedge aclk);
    endtask

    // Setup cycle, then access cycle; the register takes the word at the edge after access.
    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        logic [31:0] readback;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            tmon_pkg::REG_TEMP_WARN: begin
                lvl_temp_warn = value[SampleWidth-1:0];
                readback = 32'(lvl_temp_warn);
            end
            tmon_pkg::REG_TEMP_ERROR: begin
                lvl_temp_error = value[SampleWidth-1:0];
                readback = 32'(lvl_temp_error);
            end
            tmon_pkg::REG_BATTERY_WARN: begin
                lvl_batt_warn = value[SampleWidth-1:0];
                readback = 32'(lvl_batt_warn);
            end
            tmon_pkg::REG_BATTERY_ERROR: begin
                lvl_batt_error = value[SampleWidth-1:0];
                readback = 32'(lvl_batt_error);
            end
            tmon_pkg::REG_HYSTERESIS: begin
                hyst_margin = value[MarginWidth-1:0];
                readback = 32'(hyst_margin);
            end
            default: readback = '0;
        endcase
        // paddr still points at the register just written
        if (prdata !== readback) begin
            $error("prdata: expected 0x%08h, got 0x%08h", readback, prdata);
            mismatch_count++;
        end
        if (pready !== 1'b1) begin
            $error("pready: expected 1, got %0b", pready);
            mismatch_count++;
        end
    endtask

    task automatic set_levels(input logic [31:0] temp_warn, input logic [31:0] temp_error,
                              input logic [31:0] batt_warn, input logic [31:0] batt_error,
                              input logic [31:0] margin);
        write_register(tmon_pkg::REG_TEMP_WARN, temp_warn);
        write_register(tmon_pkg::REG_TEMP_ERROR, temp_error);
        write_register(tmon_pkg::REG_BATTERY_WARN, batt_warn);
        write_register(tmon_pkg::REG_BATTERY_ERROR, batt_error);
        write_register(tmon_pkg::REG_HYSTERESIS, margin);
    endtask

    task automatic run_samples(input int count);
        repeat (count) sample_queue.push_back(random_sample());
        settle();
    endtask

    task automatic compare_field(input string name, input logic expected, input logic actual);
        if (actual !== expected) begin
            $error("%s: expected %0b, got %0b", name, expected, actual);
            mismatch_count++;
        end
    endtask

    // Source side: present the next word once the previous one was taken.
    always @(negedge aclk) begin : feed
        sample_t next_word;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || word_in_taken) begin
            if (src_gap > 0) begin
                // hold off for the rest of the burst
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (sample_queue.size() != 0) begin
                next_word = sample_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {4'b0, next_word.battery_sample, next_word.temp_sample};
                s_axis_tuser  <= {next_word.battery_valid, next_word.temp_valid};
                if (idling_on && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 10);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: stall in random bursts while idling is on.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (idling_on && $urandom_range(0, 5) == 0) sink_gap = $urandom_range(1, 10);
        end
    end

    // Predict on every accepted sample word; check every accepted result word.
    always @(posedge aclk) begin : observe
        sample_t           in_word;
        tmon_pkg::result_t got;
        tmon_pkg::result_t want;
        if (!aresetn) begin
            word_in_taken <= 1'b0;
        end else begin
            word_in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                in_word.temp_valid     = s_axis_tuser[0];
                in_word.battery_valid  = s_axis_tuser[1];
                in_word.temp_sample    = s_axis_tdata[SampleWidth-1:0];
                in_word.battery_sample = s_axis_tdata[2*SampleWidth-1:SampleWidth];
                expected_results.push_back(predict_health(in_word));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = tmon_pkg::result_t'(m_axis_tdata);
                if (expected_results.size() == 0) begin
                    $error("result word 0x%02h arrived with nothing pending", m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("temp_alarm", want.temp_alarm, got.temp_alarm);
                    compare_field("battery_alarm", want.battery_alarm, got.battery_alarm);
                    compare_field("outputs_enabled", want.outputs_enabled,
                                  got.outputs_enabled);
                    compare_field("temp_high_flag", want.flags.temp_high,
                                  got.flags.temp_high);
                    compare_field("temp_critical_flag", want.flags.temp_critical,
                                  got.flags.temp_critical);
                    compare_field("battery_low_flag", want.flags.battery_low,
                                  got.flags.battery_low);
                    compare_field("battery_critical_flag", want.flags.battery_critical,
                                  got.flags.battery_critical);
                    compare_field("pad", want.pad, got.pad);
                end
            end
        end
    end

    // Watchdog: any handshake or register access restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || psel || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QuietLimit) begin
            $display("temp_battery_hysteresis_monitor_test: errors");
            $finish;
        end
    end

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words on the default thresholds (warn 780/580, error 820/400, margin 5).
        queue_sample(1'b0, SampleMax, 1'b0, 0);     // both absent: nothing moves
        queue_sample(1'b1, 0, 1'b0, SampleMax);     // temp far below: enable outputs
        queue_sample(1'b1, 781, 1'b0, 0);           // just above warn: high alarm
        queue_sample(1'b1, 781, 1'b0, 0);           // still high: no new alarm
        queue_sample(1'b1, 821, 1'b0, 0);           // above error: critical, outputs off
        queue_sample(1'b1, 820, 1'b0, 0);           // at error: high already set
        queue_sample(1'b1, 775, 1'b0, 0);           // inside the band: hold
        queue_sample(1'b1, 774, 1'b0, 0);           // below warn minus margin: clear
        queue_sample(1'b1, SampleMax, 1'b0, 0);     // top of range: critical again
        queue_sample(1'b0, 0, 1'b1, 0);             // battery at zero: critical alarm
        queue_sample(1'b0, 0, 1'b1, 399);           // still critical: no alarm
        queue_sample(1'b0, 0, 1'b1, 400);           // at error: low alarm
        queue_sample(1'b0, 0, 1'b1, 579);           // low already set
        queue_sample(1'b0, 0, 1'b1, 585);           // at warn plus margin: hold
        queue_sample(1'b0, 0, 1'b1, 586);           // just past the band: clear
        queue_sample(1'b0, 0, 1'b1, SampleMax);     // top of range: stays clear
        queue_sample(1'b1, SampleMax, 1'b1, 0);     // both go critical together
        queue_sample(1'b1, 0, 1'b1, SampleMax);     // both clear together
        queue_sample(1'b0, SampleMax, 1'b1, 500);   // temp absent, battery low only
        queue_sample(1'b1, 682, 1'b1, 341);         // alternating bit patterns
        queue_sample(1'b1, 341, 1'b1, 682);
        settle();
        run_samples(40);

        // Rails: every sample but temp 0 or battery max trips at once, then nothing ever trips.
        set_levels(0, 0, SampleMax, SampleMax, 63);
        run_samples(45);
        set_levels(SampleMax, SampleMax, 0, 0, 0);
        run_samples(45);

        // Error threshold on the wrong side of warn: the rule order decides.
        set_levels(900, 700, 300, 600, 9);
        queue_sample(1'b1, 800, 1'b1, 400);
        queue_sample(1'b1, 950, 1'b1, 200);
        settle();
        run_samples(45);

        // Margin larger than temp warn, and battery clear bound past the top of range.
        set_levels(20, 400, 1000, 200, 63);
        write_register(REG_SPARE, $urandom());
        queue_sample(1'b1, 0, 1'b1, SampleMax);
        settle();
        run_samples(45);

        // Random thresholds; stray upper bits of the write word must be dropped.
        repeat (3) begin
            set_levels($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
            run_samples(45);
        end

        // Last stretch at full rate on both sides.
        idling_on = 1'b0;
        set_levels(32'(tmon_pkg::TEMP_WARN_RESET), 32'(tmon_pkg::TEMP_ERROR_RESET),
                   32'(tmon_pkg::BATTERY_WARN_RESET), 32'(tmon_pkg::BATTERY_ERROR_RESET),
                   32'(tmon_pkg::HYSTERESIS_RESET));
        run_samples(45);

        if (mismatch_count == 0) begin
            $display("temp_battery_hysteresis_monitor_test: clean");
        end else begin
            $display("temp_battery_hysteresis_monitor_test: errors");
        end
        $finish;
    end

endmodule
